>>> hdl/amrf_pkg.sv
// Package for the AT modem response framer: sizes, character codes,
// frame kinds and the result beat structure.
// No dependencies; used by every module of the block.
`default_nettype none

package amrf_pkg;

  // Frame buffer size in bytes; a frame is cut once it holds this many.
  localparam int BUFFER_BYTES = 256;

  // Byte position counter width; the position never reaches BUFFER_BYTES.
  localparam int POS_W = $clog2(BUFFER_BYTES);

  // Width used to form frame lengths before they are cut to the port width.
  localparam int LEN_W      = 9;
  localparam int LEN_CALC_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;

  // Length accumulator and end position widths.
  localparam int ACC_W = 16;
  localparam int END_W = 17;

  // "+IPD" with the earliest byte in the top byte.
  localparam logic [31:0] HEADER_WORD = 32'h2B49_5044;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_PROMPT  = 8'h3E;

  // Frame kinds.
  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  // One result beat.
  typedef struct packed {
    logic [7:0]       byte_out;
    logic             byte_kept;
    logic             frame_done;
    logic [1:0]       frame_kind;
    logic [LEN_W-1:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/at_modem_response_framer_core.sv
// Top level of the AT modem response framer: input register, framing logic
// and output register. Depends on amrf_pkg, amrf_framer and amrf_out_stage.
// A byte accepted on the slave side passes through the input register and then
// the output register before its result beat is offered on the master side.
// Throughput: one byte per cycle, limited only by the downstream tready; the
// input register and the output register each hold one beat.
// Reset (rst, synchronous, active high) empties both registers and clears
// the framing state, so the first byte after reset starts a new frame.
`default_nettype none

module at_modem_response_framer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // [7:0] byte_out, [16:8] frame_length
  output logic             m_tlast,  // frame_done
  output logic [2:0]       m_tuser   // [0] byte_kept, [2:1] frame_kind
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              room;
  logic              advance;
  amrf_pkg::result_t result;

  // The held byte moves on whenever the output register has room.
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || room;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata[7:0];
    end
  end

  amrf_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .result  (result)
  );

  amrf_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

>>> hdl/amrf_framer.sv
// Framing state and the per-byte decision logic of the AT modem response
// framer. Depends on amrf_pkg.
`default_nettype none

module amrf_framer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,     // the byte is consumed this cycle
  input  wire logic [7:0]       rx_byte,
  output amrf_pkg::result_t     result
);

  logic [amrf_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]                first_four_bytes, first_four_bytes_next;
  logic                       in_data_frame, in_data_frame_next;
  logic                       length_known, length_known_next;
  logic [amrf_pkg::ACC_W-1:0] digit_accumulator, digit_accumulator_next;
  logic [amrf_pkg::END_W-1:0] data_end_position, data_end_position_next;
  logic                       comma_seen, comma_seen_next;

  logic                            is_data;
  logic                            is_digit;
  logic                            at_last_slot;
  logic [19:0]                     acc_times_ten;
  logic [19:0]                     acc_sum;
  logic [amrf_pkg::LEN_CALC_W-1:0] pos_wide;
  logic [amrf_pkg::LEN_CALC_W-1:0] len_calc;
  logic                            kept, done;
  logic [1:0]                      kind;

  assign pos_wide     = amrf_pkg::LEN_CALC_W'(byte_position);
  assign at_last_slot = (byte_position == amrf_pkg::POS_W'(amrf_pkg::BUFFER_BYTES - 1));
  assign is_digit     = (rx_byte >= amrf_pkg::CHAR_ZERO) && (rx_byte <= amrf_pkg::CHAR_NINE);

  // Decimal accumulate: acc * 10 + digit, saturated to 16 bits.
  assign acc_times_ten = {1'b0, digit_accumulator, 3'b000} + {3'b000, digit_accumulator, 1'b0};
  assign acc_sum       = acc_times_ten + 20'(rx_byte - amrf_pkg::CHAR_ZERO);

  // Next state and result for the byte at the input register.
  always_comb begin
    byte_position_next     = byte_position;
    first_four_bytes_next  = first_four_bytes;
    length_known_next      = length_known;
    digit_accumulator_next = digit_accumulator;
    data_end_position_next = data_end_position;
    comma_seen_next        = comma_seen;
    kept                   = 1'b1;
    done                   = 1'b0;
    kind                   = amrf_pkg::KIND_LINE;
    len_calc               = '0;

    is_data = in_data_frame ||
              ((byte_position == amrf_pkg::POS_W'(4)) &&
               (first_four_bytes == amrf_pkg::HEADER_WORD));
    in_data_frame_next = is_data;

    if (is_data) begin
      // Length parsing up to the colon that follows a comma.
      if (!length_known) begin
        if (rx_byte == amrf_pkg::CHAR_COMMA) begin
          comma_seen_next        = 1'b1;
          digit_accumulator_next = '0;
        end else if (is_digit) begin
          digit_accumulator_next = (acc_sum[19:16] != 4'd0) ? '1 : acc_sum[15:0];
        end else if ((rx_byte == amrf_pkg::CHAR_COLON) && comma_seen) begin
          length_known_next      = 1'b1;
          data_end_position_next = amrf_pkg::END_W'(byte_position) +
                                   amrf_pkg::END_W'(digit_accumulator);
        end
      end
      if (length_known_next &&
          (data_end_position_next == amrf_pkg::END_W'(byte_position))) begin
        done     = 1'b1;
        kind     = amrf_pkg::KIND_DATA;
        len_calc = pos_wide + amrf_pkg::LEN_CALC_W'(1);
      end else if (at_last_slot) begin
        done     = 1'b1;
        kind     = amrf_pkg::KIND_FULL;
        len_calc = pos_wide + amrf_pkg::LEN_CALC_W'(1);
      end else begin
        byte_position_next = byte_position + amrf_pkg::POS_W'(1);
      end
    end else begin
      // Line and prompt frames.
      if (rx_byte == amrf_pkg::CHAR_NEWLINE) begin
        kept     = 1'b0;
        done     = 1'b1;
        len_calc = pos_wide;
      end else if ((byte_position == '0) && (rx_byte == amrf_pkg::CHAR_PROMPT)) begin
        done     = 1'b1;
        len_calc = amrf_pkg::LEN_CALC_W'(1);
      end else if (at_last_slot) begin
        done     = 1'b1;
        kind     = amrf_pkg::KIND_FULL;
        len_calc = pos_wide + amrf_pkg::LEN_CALC_W'(1);
      end else begin
        if (byte_position < amrf_pkg::POS_W'(4)) begin
          first_four_bytes_next = {first_four_bytes[23:0], rx_byte};
        end
        byte_position_next = byte_position + amrf_pkg::POS_W'(1);
      end
    end

    // A finished frame returns every state entry to zero.
    if (done) begin
      byte_position_next     = '0;
      first_four_bytes_next  = '0;
      in_data_frame_next     = 1'b0;
      length_known_next      = 1'b0;
      digit_accumulator_next = '0;
      data_end_position_next = '0;
      comma_seen_next        = 1'b0;
    end
  end

  assign result.byte_out     = rx_byte;
  assign result.byte_kept    = kept;
  assign result.frame_done   = done;
  assign result.frame_kind   = kind;
  assign result.frame_length = len_calc[amrf_pkg::LEN_W-1:0];

  // Framing state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      first_four_bytes  <= '0;
      in_data_frame     <= 1'b0;
      length_known      <= 1'b0;
      digit_accumulator <= '0;
      data_end_position <= '0;
      comma_seen        <= 1'b0;
    end else if (fire) begin
      byte_position     <= byte_position_next;
      first_four_bytes  <= first_four_bytes_next;
      in_data_frame     <= in_data_frame_next;
      length_known      <= length_known_next;
      digit_accumulator <= digit_accumulator_next;
      data_end_position <= data_end_position_next;
      comma_seen        <= comma_seen_next;
    end
  end

`ifndef SYNTHESIS
  // The length is only fixed inside a data frame.
  a_known_in_data: assert property (@(posedge clk) disable iff (rst)
    length_known |-> in_data_frame)
    else $error("length fixed outside a data frame");

  // A consumed byte that ends a frame leaves the position at zero.
  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    (fire && done) |=> (byte_position == '0) && !in_data_frame && !comma_seen)
    else $error("frame state not cleared after frame end");

  // A dropped byte is always a newline ending a line frame.
  a_dropped_is_line_end: assert property (@(posedge clk) disable iff (rst)
    !kept |-> (done && (kind == amrf_pkg::KIND_LINE) && !is_data))
    else $error("dropped byte outside a line frame end");

  // Tags are zero on bytes that do not end a frame.
  a_tags_idle: assert property (@(posedge clk) disable iff (rst)
    !done |-> ((kind == amrf_pkg::KIND_LINE) && (len_calc == '0)))
    else $error("frame tags set on a byte inside a frame");
`endif

endmodule

`default_nettype wire

>>> hdl/amrf_out_stage.sv
// Output register of the AT modem response framer: holds one result beat
// until the downstream side takes it. Depends on amrf_pkg.
`default_nettype none

module amrf_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,   // a new result enters this cycle
  input  wire amrf_pkg::result_t result,
  output logic                   room,   // a result can enter this cycle
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [23:0]            m_tdata, // [7:0] byte_out, [16:8] frame_length
  output logic                   m_tlast, // frame_done
  output logic [2:0]             m_tuser  // [0] byte_kept, [2:1] frame_kind
);

  amrf_pkg::result_t held;

  assign room = !m_tvalid || m_tready;

  // Valid flag follows loads and downstream takes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  // Payload is captured with each load.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {7'd0, held.frame_length, held.byte_out};
  assign m_tlast = held.frame_done;
  assign m_tuser = {held.frame_kind, held.byte_kept};

endmodule

`default_nettype wire

>>> tb/sv/amrf_frame_checker.sv
// Scoreboard for the AT modem response framer: predicts the tags of every
// byte accepted on the slave side and compares them with the master side.
// Depends on amrf_pkg for sizes, character codes, frame kinds and result_t.
`timescale 1ns / 1ps

module amrf_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,   // [7:0] byte_out, [16:8] frame_length
  input  wire logic        m_tlast,   // frame_done
  input  wire logic [2:0]  m_tuser,   // [0] byte_kept, [2:1] frame_kind
  output int               fail_count,
  output int               pending_beats
);

  // Framing state of the predictor.
  int unsigned  frame_pos;
  logic [31:0]  header_bytes;
  bit           in_data;
  bit           length_fixed;
  bit           comma_seen;
  int unsigned  length_acc;
  logic [16:0]  data_end;

  amrf_pkg::result_t expected_beats[$];
  amrf_pkg::result_t want;
  amrf_pkg::result_t got;

  function void clear_frame();
    frame_pos    = 0;
    header_bytes = '0;
    in_data      = 1'b0;
    length_fixed = 1'b0;
    comma_seen   = 1'b0;
    length_acc   = 0;
    data_end     = '0;
  endfunction

  // Works out the tags of one received byte and advances the framing state.
  function automatic amrf_pkg::result_t frame_byte(logic [7:0] b);
    amrf_pkg::result_t r;
    int unsigned       p;
    int unsigned       len;
    bit                done;
    p            = frame_pos;
    len          = 0;
    done         = 1'b0;
    r.byte_out   = b;
    r.byte_kept  = 1'b1;
    r.frame_kind = amrf_pkg::KIND_LINE;

    // The fifth byte decides whether this frame carries "+IPD" data.
    if (p == 4 && header_bytes == amrf_pkg::HEADER_WORD) in_data = 1'b1;

    if (in_data) begin
      // Length parsing runs until the first colon after a comma.
      if (!length_fixed) begin
        if (b == amrf_pkg::CHAR_COMMA) begin
          comma_seen = 1'b1;
          length_acc = 0;
        end else if (b >= amrf_pkg::CHAR_ZERO && b <= amrf_pkg::CHAR_NINE) begin
          length_acc = length_acc * 10 + (b - amrf_pkg::CHAR_ZERO);
          if (length_acc > 65535) length_acc = 65535;
        end else if (b == amrf_pkg::CHAR_COLON && comma_seen) begin
          length_fixed = 1'b1;
          data_end     = 17'(p + length_acc);
        end
      end
      if (length_fixed && data_end == p) begin
        done = 1'b1;
        r.frame_kind = amrf_pkg::KIND_DATA;
        len = p + 1;
      end else if (p + 1 >= amrf_pkg::BUFFER_BYTES) begin
        done = 1'b1;
        r.frame_kind = amrf_pkg::KIND_FULL;
        len = p + 1;
      end else begin
        frame_pos = p + 1;
      end
    end else begin
      // Line frames: newline is dropped, a leading '>' is a prompt.
      if (b == amrf_pkg::CHAR_NEWLINE) begin
        r.byte_kept = 1'b0;
        done = 1'b1;
        len = p;
      end else if (p == 0 && b == amrf_pkg::CHAR_PROMPT) begin
        done = 1'b1;
        len = 1;
      end else if (p + 1 >= amrf_pkg::BUFFER_BYTES) begin
        done = 1'b1;
        r.frame_kind = amrf_pkg::KIND_FULL;
        len = p + 1;
      end else begin
        if (p < 4) header_bytes = {header_bytes[23:0], b};
        frame_pos = p + 1;
      end
    end

    if (done) clear_frame();
    r.frame_done   = done;
    r.frame_length = len[amrf_pkg::LEN_W-1:0];
    return r;
  endfunction

  // Predict on each accepted input beat, compare on each accepted output beat.
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      expected_beats.delete();
      fail_count    = 0;
      pending_beats <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_beats.push_back(frame_byte(s_tdata));
      if (m_tvalid && m_tready) begin
        got.byte_out     = m_tdata[7:0];
        got.frame_length = m_tdata[16:8];
        got.frame_done   = m_tlast;
        got.byte_kept    = m_tuser[0];
        got.frame_kind   = m_tuser[2:1];
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat: byte_out %02h", got.byte_out);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (got.byte_out !== want.byte_out) begin
            $error("byte_out: expected %02h, got %02h", want.byte_out, got.byte_out);
            fail_count++;
          end
          if (got.byte_kept !== want.byte_kept) begin
            $error("byte_kept: expected %0d, got %0d", want.byte_kept, got.byte_kept);
            fail_count++;
          end
          if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
            fail_count++;
          end
          if (got.frame_kind !== want.frame_kind) begin
            $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
            fail_count++;
          end
          if (got.frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d",
                   want.frame_length, got.frame_length);
            fail_count++;
          end
        end
      end
      pending_beats <= expected_beats.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the AT modem response framer testbench: clock, reset, byte stimulus
// with random gaps, random downstream stalls and the final verdict.
// Depends on amrf_pkg, at_modem_response_framer_core and amrf_frame_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int ITEM_TARGET  = 1950;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;

  int fail_count;
  int pending_beats;
  int sent_bytes = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;

  logic [7:0] byte_plan[$];

  at_modem_response_framer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  amrf_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one byte on the slave side and waits for its beat.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic flush_plan();
    while (byte_plan.size() > 0) send_byte(byte_plan.pop_front());
  endtask

  function automatic void plan_text(string s);
    for (int i = 0; i < s.len(); i++) byte_plan.push_back(s[i]);
  endfunction

  // Payload bytes over the full range, with framing characters mixed in.
  function automatic void plan_payload(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)       byte_plan.push_back(amrf_pkg::CHAR_NEWLINE);
      else if (r < 9)  byte_plan.push_back(amrf_pkg::CHAR_PROMPT);
      else if (r < 12) byte_plan.push_back(amrf_pkg::CHAR_COLON);
      else if (r < 15) byte_plan.push_back(amrf_pkg::CHAR_COMMA);
      else             byte_plan.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Decimal length, sometimes with a leading zero or stray non-digits.
  function automatic void plan_length(int v);
    string d;
    d = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) plan_text("0");
    for (int i = 0; i < d.len(); i++) begin
      byte_plan.push_back(d[i]);
      if ($urandom_range(0, 9) == 0) plan_text(" ");
    end
  endfunction

  // A well-formed "+IPD" frame; a few run past the buffer size.
  function automatic void plan_data_frame();
    int r;
    int plen;
    plan_text("+IPD");
    if ($urandom_range(0, 1) == 1) begin
      plan_text(",");
      byte_plan.push_back(8'(amrf_pkg::CHAR_ZERO + $urandom_range(0, 4)));
    end
    plan_text(",");
    r = $urandom_range(0, 99);
    if (r < 90) begin
      plen = $urandom_range(0, 40);
      plan_length(plen);
    end else if (r < 96) begin
      plen = $urandom_range(41, 300);
      plan_length(plen);
    end else begin
      // Far too many digits: the length saturates and the buffer fills.
      plan_text("99999");
      plan_length($urandom_range(0, 999));
      plen = 270;
    end
    plan_text(":");
    plan_payload(plen > 270 ? 270 : plen);
  endfunction

  function automatic void plan_line();
    int n;
    n = $urandom_range(0, 30);
    for (int i = 0; i < n; i++) byte_plan.push_back(8'($urandom_range(8'h20, 8'h7E)));
    if ($urandom_range(0, 4) == 0) plan_text("\r");
    plan_text("\n");
  endfunction

  function automatic void plan_long_line();
    int n;
    n = $urandom_range(250, 270);
    for (int i = 0; i < n; i++) byte_plan.push_back(8'($urandom_range(8'h41, 8'h7A)));
    plan_text("\n");
  endfunction

  function automatic void plan_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) byte_plan.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Near misses of the data header and data frames with a colon too early.
  function automatic void plan_broken();
    int n;
    case ($urandom_range(0, 2))
      0: begin
        plan_text("+IPD");
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1) == 1) plan_text(":");
          else byte_plan.push_back(8'(amrf_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        plan_text(",");
        plan_length($urandom_range(0, 8));
        plan_text(":");
        plan_payload($urandom_range(0, 8));
      end
      1: begin
        plan_text("+IP");
        byte_plan.push_back(8'($urandom_range(8'h41, 8'h43)));
        plan_text(",2:\n");
      end
      default: plan_text("x+IPD,3:\n");
    endcase
  endfunction

  // Downstream side: random stalls, with stretches of steady acceptance.
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) receiver_steady <= !receiver_steady;
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!receiver_steady && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty line, prompt, '>' later in a line, extreme byte values,
    // zero-length data, colon before the comma and newline inside data.
    plan_text("\n");
    plan_text(">");
    plan_text("A>\n");
    byte_plan.push_back(8'hFF);
    byte_plan.push_back(8'h00);
    plan_text("\n");
    plan_text("+IPD,0:");
    plan_text("+IPD:,1:\n");
    flush_plan();

    // Random frames until enough bytes have gone in.
    while (sent_bytes < ITEM_TARGET) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      plan_data_frame();
      else if (pick < 66) plan_line();
      else if (pick < 73) plan_text(">");
      else if (pick < 84) plan_noise();
      else if (pick < 97) plan_broken();
      else                plan_long_line();
      flush_plan();
    end
    s_tvalid <= 1'b0;

    // Drain the pipeline, then give stray beats a chance to show.
    do @(posedge clk); while (pending_beats != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> at_modem_response_framer_core.f
hdl/amrf_pkg.sv
hdl/amrf_framer.sv
hdl/amrf_out_stage.sv
hdl/at_modem_response_framer_core.sv
tb/sv/amrf_frame_checker.sv
tb/sv/testbench.sv
